// ----- src/utx_pkg.sv -----
// Shared types and constants for the UART transmit register block.
`timescale 1ns / 1ps
package utx_pkg;

  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_WRITE = 2'd2;

  localparam logic [1:0] OP_NOP   = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_WRITE = 2'd3;

  localparam logic [2:0] REG_THR = 3'd0;
  localparam logic [2:0] REG_IER = 3'd1;
  localparam logic [2:0] REG_FCR = 3'd2;
  localparam logic [2:0] REG_LCR = 3'd3;
  localparam logic [2:0] REG_MCR = 3'd4;
  localparam logic [2:0] REG_LSR = 3'd5;
  localparam logic [2:0] REG_MSR = 3'd6;
  localparam logic [2:0] REG_SCR = 3'd7;

  localparam logic [7:0] LSR_HOLD_EMPTY = 8'h20;
  localparam logic [7:0] LSR_SHIFT_IDLE = 8'h40;
  localparam logic [7:0] IIR_NO_INT     = 8'h01;
  localparam logic [7:0] IIR_FIFO       = 8'hC1;

  localparam int OVERSAMPLE = 16;
  localparam int OS_W       = 4;
  localparam int FRAME_W    = 12;
  localparam int BITS_W     = 4;
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] offset;
    logic [7:0] data;
  } op_t;

endpackage

// ----- src/utx_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module utx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- src/utx_front.sv -----
// Front end: accepts items and classifies them into operations.
`timescale 1ns / 1ps
module utx_front
  import utx_pkg::*;
(
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_func,
  input  logic [2:0] in_reg_offset,
  input  logic [7:0] in_write_data,
  input  logic       q_full,
  output logic       push,
  output op_t        push_op
);

  always_comb begin
    push_op.offset = in_reg_offset;
    push_op.data   = in_write_data;
    case (in_func)
      FUNC_TICK:  push_op.kind = OP_TICK;
      FUNC_READ:  push_op.kind = OP_READ;
      FUNC_WRITE: push_op.kind = OP_WRITE;
      default:    push_op.kind = OP_NOP;
    endcase
  end

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

endmodule

// ----- src/utx_queue.sv -----
// Two-entry queue of decoded operations between front and back.
`timescale 1ns / 1ps
module utx_queue
  import utx_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  op_t  push_op,
  output logic full,
  input  logic pop,
  output logic op_valid,
  output op_t  op
);

  op_t        ent_r [QUEUE_DEPTH];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_op;
    end
  end

  assign full     = (count_r == 2'(QUEUE_DEPTH));
  assign op_valid = (count_r != 2'd0);
  assign op       = ent_r[rd_ptr_r];

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 2'(QUEUE_DEPTH))
    else $error("queue count out of range");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> op_valid)
    else $error("pop while queue empty");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push while queue full");
`endif

endmodule

// ----- src/utx_back.sv -----
// Back end: register file, TX store, baud generator, shifter and result register.
`timescale 1ns / 1ps
module utx_back
  import utx_pkg::*;
#(
  parameter int FIFO_DEPTH = 16,
  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1,
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             op_valid,
  input  op_t              op,
  output logic             pop,
  input  logic             out_stall,
  output logic             out_valid,
  output logic [7:0]       out_read_data,
  output logic             out_txd,
  output logic             ram_we,
  output logic [PTR_W-1:0] ram_waddr,
  output logic [7:0]       ram_wdata,
  output logic [PTR_W-1:0] ram_raddr,
  input  logic [7:0]       ram_rdata
);

  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [PTR_W-1:0]   head_r, head_nxt;
  logic [PTR_W-1:0]   tail_r, tail_nxt;
  logic               fen_r, fen_nxt;
  logic [7:0]         lcr_r, lcr_nxt;
  logic [4:0]         mcr_r, mcr_nxt;
  logic [3:0]         ier_r, ier_nxt;
  logic [15:0]        div_r, div_nxt;
  logic [7:0]         scr_r, scr_nxt;
  logic [15:0]        baud_r, baud_nxt;
  logic [OS_W-1:0]    os_r, os_nxt;
  logic [FRAME_W-1:0] sf_r, sf_nxt;
  logic [BITS_W-1:0]  bits_r, bits_nxt;
  logic               byp_r;
  logic [7:0]         byp_data_r;
  logic               out_valid_r;
  logic [7:0]         out_read_data_r;
  logic               out_txd_r;

  logic               exec;
  logic [7:0]         rd_val;
  logic [7:0]         head_data;
  logic [CNT_W-1:0]   cap;
  logic               dlab;
  logic               is_tick, is_read, is_write;
  logic               ld, pulse, fcr_en;
  logic [3:0]         wl, pos;
  logic [7:0]         dmask, dm;
  logic [11:0]        dm_ext;
  logic               par;
  logic [FRAME_W-1:0] frame_ld;
  logic [BITS_W-1:0]  bits_a;
  logic [OS_W-1:0]    os_a;
  logic [FRAME_W-1:0] sf_a;
  logic [OS_W:0]      os_inc;
  logic               txd_nxt;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(FIFO_DEPTH - 1)) begin
      return '0;
    end
    return p + PTR_W'(1);
  endfunction

  assign exec      = op_valid && (!out_valid_r || !out_stall);
  assign pop       = exec;
  assign is_tick   = exec && (op.kind == OP_TICK);
  assign is_read   = exec && (op.kind == OP_READ);
  assign is_write  = exec && (op.kind == OP_WRITE);
  assign dlab      = lcr_r[7];
  assign head_data = byp_r ? byp_data_r : ram_rdata;
  assign cap       = fen_r ? CNT_W'(FIFO_DEPTH) : CNT_W'(1);

  // frame assembly from the head byte under the current LCR
  always_comb begin
    wl     = {2'b00, lcr_r[1:0]} + 4'd5;
    pos    = 4'd1 + wl + {3'b000, lcr_r[3]} + (lcr_r[2] ? 4'd2 : 4'd1);
    dmask  = 8'hFF >> (2'd3 - lcr_r[1:0]);
    dm     = head_data & dmask;
    dm_ext = {4'b0000, dm};
    par    = lcr_r[5] ? ~lcr_r[4] : ((^dm) ^ ~lcr_r[4]);
    frame_ld    = '0;
    frame_ld[0] = 1'b0;
    for (int i = 1; i < FRAME_W; i++) begin
      if (4'(i) <= wl) begin
        frame_ld[i] = dm_ext[i-1];
      end else if (lcr_r[3] && (4'(i) == wl + 4'd1)) begin
        frame_ld[i] = par;
      end else if (4'(i) < pos) begin
        frame_ld[i] = 1'b1;
      end else begin
        frame_ld[i] = 1'b0;
      end
    end
  end

  // register read
  always_comb begin
    rd_val = 8'h00;
    case (op.offset)
      REG_THR: rd_val = dlab ? div_r[7:0] : 8'h00;
      REG_IER: rd_val = dlab ? div_r[15:8] : {4'h0, ier_r};
      REG_FCR: rd_val = fen_r ? IIR_FIFO : IIR_NO_INT;
      REG_LCR: rd_val = lcr_r;
      REG_MCR: rd_val = {3'b000, mcr_r};
      REG_LSR: rd_val = (cnt_r != '0) ? 8'h00 :
                        (LSR_HOLD_EMPTY | ((bits_r == '0) ? LSR_SHIFT_IDLE : 8'h00));
      REG_MSR: rd_val = mcr_r[4] ? {mcr_r[3], mcr_r[2], mcr_r[0], mcr_r[1], 4'h0} : 8'h00;
      REG_SCR: rd_val = scr_r;
      default: rd_val = 8'h00;
    endcase
  end

  // state update
  always_comb begin
    cnt_nxt   = cnt_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    fen_nxt   = fen_r;
    lcr_nxt   = lcr_r;
    mcr_nxt   = mcr_r;
    ier_nxt   = ier_r;
    div_nxt   = div_r;
    scr_nxt   = scr_r;
    baud_nxt  = baud_r;
    ram_we    = 1'b0;
    ram_waddr = tail_r;
    ram_wdata = op.data;
    fcr_en    = op.data[0];

    ld     = is_tick && (bits_r == '0) && (cnt_r != '0);
    bits_a = ld ? pos : bits_r;
    os_a   = ld ? '0 : os_r;
    sf_a   = ld ? frame_ld : sf_r;
    pulse  = is_tick && (div_r != 16'd0) && (baud_r >= div_r - 16'd1);
    os_inc = {1'b0, os_a} + 5'd1;
    os_nxt   = os_a;
    sf_nxt   = sf_a;
    bits_nxt = bits_a;

    if (ld) begin
      head_nxt = ptr_inc(head_r);
      cnt_nxt  = cnt_r - CNT_W'(1);
    end
    if (is_tick && (div_r != 16'd0)) begin
      baud_nxt = pulse ? 16'd0 : baud_r + 16'd1;
    end
    if (pulse && (bits_a != '0)) begin
      if (os_inc >= 5'(OVERSAMPLE)) begin
        os_nxt   = '0;
        sf_nxt   = {1'b1, sf_a[FRAME_W-1:1]};
        bits_nxt = bits_a - BITS_W'(1);
      end else begin
        os_nxt = os_inc[OS_W-1:0];
      end
    end

    if (is_write) begin
      case (op.offset)
        REG_THR: begin
          if (dlab) begin
            div_nxt[7:0] = op.data;
          end else if (cnt_r < cap) begin
            ram_we    = 1'b1;
            ram_waddr = tail_r;
            tail_nxt  = ptr_inc(tail_r);
            cnt_nxt   = cnt_r + CNT_W'(1);
          end else if (!fen_r) begin
            ram_we    = 1'b1;
            ram_waddr = head_r;
          end
        end
        REG_IER: begin
          if (dlab) begin
            div_nxt[15:8] = op.data;
          end else begin
            ier_nxt = op.data[3:0];
          end
        end
        REG_FCR: begin
          if ((fcr_en != fen_r) || (fcr_en && op.data[2])) begin
            cnt_nxt  = '0;
            head_nxt = '0;
            tail_nxt = '0;
          end
          fen_nxt = fcr_en;
        end
        REG_LCR: lcr_nxt = op.data;
        REG_MCR: mcr_nxt = op.data[4:0];
        REG_SCR: scr_nxt = op.data;
        default: ;
      endcase
    end

    txd_nxt = mcr_nxt[4] ? 1'b1 :
              lcr_nxt[6] ? 1'b0 :
              (bits_nxt != '0) ? sf_nxt[0] : 1'b1;
  end

  assign ram_raddr = head_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      fen_r       <= 1'b0;
      lcr_r       <= 8'h00;
      mcr_r       <= 5'h00;
      ier_r       <= 4'h0;
      div_r       <= 16'h0000;
      scr_r       <= 8'h00;
      baud_r      <= 16'h0000;
      os_r        <= '0;
      sf_r        <= '1;
      bits_r      <= '0;
      byp_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      fen_r  <= fen_nxt;
      lcr_r  <= lcr_nxt;
      mcr_r  <= mcr_nxt;
      ier_r  <= ier_nxt;
      div_r  <= div_nxt;
      scr_r  <= scr_nxt;
      baud_r <= baud_nxt;
      os_r   <= os_nxt;
      sf_r   <= sf_nxt;
      bits_r <= bits_nxt;
      byp_r  <= ram_we && (ram_waddr == ram_raddr);
      if (exec) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    byp_data_r <= ram_wdata;
    if (exec) begin
      out_read_data_r <= is_read ? rd_val : 8'h00;
      out_txd_r       <= txd_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_read_data_r;
  assign out_txd       = out_txd_r;

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r <= CNT_W'(FIFO_DEPTH)) && (fen_r || (cnt_r <= CNT_W'(1))))
    else $error("TX store count exceeds capacity");
  a_bits_range: assert property (@(posedge clk) disable iff (!rst_n)
    bits_r <= BITS_W'(FRAME_W))
    else $error("frame bit count out of range");
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ld |-> (bits_r == '0) && (cnt_r != '0))
    else $error("frame load while shifter busy or store empty");
`endif

endmodule

// ----- src/uart_16550_tx_register_block.sv -----
// Top level of the 16550-style UART transmit register block.
// An accepted item is written into the two-entry queue, executes from it once the output
// is not stalled, and its result is then held in the registered result outputs.
// Throughput: one item per cycle while the output is not stalled; the single execute stage
// in the back end handles one tick, read or write each cycle that it is not stalled.
// Reset: all control and UART registers clear; the TXD output register is not reset; FIFO
// entries are undefined until written and need no clearing pass.
`timescale 1ns / 1ps
module uart_16550_tx_register_block
  import utx_pkg::*;
#(
  parameter int FIFO_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_func,
  input  logic [2:0] in_reg_offset,
  input  logic [7:0] in_write_data,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_read_data,
  output logic       out_txd
);

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

  logic             push, q_full, pop, op_valid;
  op_t              push_op, op;
  logic             ram_we;
  logic [PTR_W-1:0] ram_waddr, ram_raddr;
  logic [7:0]       ram_wdata, ram_rdata;

  utx_front u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_func       (in_func),
    .in_reg_offset (in_reg_offset),
    .in_write_data (in_write_data),
    .q_full        (q_full),
    .push          (push),
    .push_op       (push_op)
  );

  utx_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_op  (push_op),
    .full     (q_full),
    .pop      (pop),
    .op_valid (op_valid),
    .op       (op)
  );

  utx_ram #(
    .WIDTH (8),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  utx_back #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .op_valid      (op_valid),
    .op            (op),
    .pop           (pop),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_read_data (out_read_data),
    .out_txd       (out_txd),
    .ram_we        (ram_we),
    .ram_waddr     (ram_waddr),
    .ram_wdata     (ram_wdata),
    .ram_raddr     (ram_raddr),
    .ram_rdata     (ram_rdata)
  );

endmodule
